FILE: hdl/pbtp_pkg.sv
// Package of shared types, constants and codes for the Poisson-binomial team probability core.
`timescale 1ns / 1ps

package pbtp_pkg;

    // Default sizing of the core.
    localparam int MAX_PROBLEMS_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    // Configuration register layout.
    localparam int CFG_W       = 6;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CFG_W-1:0] NUM_PROBLEMS_RST = CFG_W'(30);
    localparam logic [CFG_W-1:0] MIN_CHAMP_RST    = CFG_W'(1);

    // Register index, taken from byte address bit 2.
    typedef enum logic [0:0] {
        REG_NUM_PROBLEMS = 1'b0,
        REG_MIN_CHAMP    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] num_problems;
        logic [CFG_W-1:0] min_champion_solved;
    } t_cfg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SWEEP,
        ST_MUL_NZ,
        ST_MUL_BM,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/pbtp_in_if.sv
// Input channel interface: one success probability per transaction.
`timescale 1ns / 1ps

interface pbtp_in_if #(
    parameter int W = pbtp_pkg::FRAC_BITS_DEF + 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] success_prob;
    logic         last_team;

    modport source (output valid, output success_prob, output last_team, input ready);
    modport sink   (input valid, input success_prob, input last_team, output ready);
endinterface

FILE: hdl/pbtp_out_if.sv
// Output channel interface: one case probability per transaction.
`timescale 1ns / 1ps

interface pbtp_out_if #(
    parameter int W = pbtp_pkg::FRAC_BITS_DEF + 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] answer_prob;

    modport source (output valid, output answer_prob, input ready);
    modport sink   (input valid, input answer_prob, output ready);
endinterface

FILE: hdl/pbtp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pbtp_ram #(
    parameter int WIDTH = pbtp_pkg::FRAC_BITS_DEF + 1,
    parameter int DEPTH = pbtp_pkg::MAX_PROBLEMS_DEF + 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/pbtp_mac.sv
// Shared multiply-accumulate unit: (a * b + (hi << F if add_en)) >> F, clamped to 0..1.0.
`timescale 1ns / 1ps

module pbtp_mac #(
    parameter int FRAC_BITS = pbtp_pkg::FRAC_BITS_DEF
) (
    input  logic signed [FRAC_BITS+1:0] i_a,
    input  logic        [FRAC_BITS:0]   i_b,
    input  logic                        i_add_en,
    input  logic        [FRAC_BITS:0]   i_hi,
    output logic        [FRAC_BITS:0]   o_res
);

    localparam int W  = FRAC_BITS + 1;
    localparam int PW = 2 * W + 2;

    localparam logic signed [PW-1:0] ONE_X = {{(W + 2){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] addend;
    logic signed [PW-1:0] acc;
    logic signed [PW-1:0] shifted;

    always_comb begin
        prod    = PW'(i_a) * $signed(PW'({1'b0, i_b}));
        addend  = i_add_en ? ($signed(PW'({1'b0, i_hi})) <<< FRAC_BITS) : '0;
        acc     = prod + addend;
        shifted = acc >>> FRAC_BITS;
        // Truncated fixed-point results never go negative; clamp for safety.
        if (acc < 0) begin
            o_res = '0;
        end else if (shifted > ONE_X) begin
            o_res = ONE_X[W-1:0];
        end else begin
            o_res = shifted[W-1:0];
        end
    end

endmodule

FILE: hdl/pbtp_cfg.sv
// APB configuration registers: problem count and champion minimum.
`timescale 1ns / 1ps

module pbtp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbtp_pkg::APB_AW-1:0] paddr,
    input  logic [pbtp_pkg::APB_DW-1:0] pwdata,
    output logic [pbtp_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output pbtp_pkg::t_cfg              o_cfg
);

    pbtp_pkg::t_cfg     r_cfg;
    pbtp_pkg::t_reg_idx reg_idx;

    assign reg_idx = pbtp_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_problems        <= pbtp_pkg::NUM_PROBLEMS_RST;
            r_cfg.min_champion_solved <= pbtp_pkg::MIN_CHAMP_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                pbtp_pkg::REG_NUM_PROBLEMS: begin
                    r_cfg.num_problems <= pwdata[pbtp_pkg::CFG_W-1:0];
                end
                pbtp_pkg::REG_MIN_CHAMP: begin
                    r_cfg.min_champion_solved <= pwdata[pbtp_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pbtp_pkg::REG_NUM_PROBLEMS: prdata = pbtp_pkg::APB_DW'(r_cfg.num_problems);
            pbtp_pkg::REG_MIN_CHAMP:    prdata = pbtp_pkg::APB_DW'(r_cfg.min_champion_solved);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/poisson_binomial_team_probability_core.sv
// Top level of the Poisson-binomial team probability core: sequencer, distribution store and glue.
// The core takes one success probability per input transaction (Q1.16 by default, saturated
// at 1.0) and folds it into a distribution of solved counts held in a small RAM, using
// new[j] = old[j] + ((old[j-1] - old[j]) * p >> F), which equals the usual two-product form
// bit for bit. A single multiply-accumulate unit walks the distribution from the top entry
// down to entry zero, one entry per cycle, so each probability occupies the core for a whole
// sweep, during which ready is low. The probability that completes a team (num_problems of
// them, clamped to 1..MAX_PROBLEMS) also passes through the MUL_NZ, MUL_BM and DONE states:
// the same unit multiplies the all-teams-nonzero product by 1 - P(0) and the below-minimum
// product by P(1..min-1), and the distribution is cleared at once through per-entry valid
// bits, so no clearing pass is needed after reset either. If that team carries the last-team
// flag, the difference of the two products appears as one output transaction and both
// products return to 1.0. The result sits in an output register, so the next probability
// is taken while it waits; only a second case result finishing before the first is taken
// makes the core wait. Configuration is written over APB by the user at byte addresses 0
// (num_problems) and 4 (min_champion_solved) only while the core is idle; it is not enforced.
`timescale 1ns / 1ps

module poisson_binomial_team_probability_core #(
    parameter int MAX_PROBLEMS = pbtp_pkg::MAX_PROBLEMS_DEF,
    parameter int FRAC_BITS    = pbtp_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pbtp_in_if.sink                     i_in,
    pbtp_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbtp_pkg::APB_AW-1:0] paddr,
    input  logic [pbtp_pkg::APB_DW-1:0] pwdata,
    output logic [pbtp_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int W     = FRAC_BITS + 1;
    localparam int DEPTH = MAX_PROBLEMS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = W + AW;
    localparam int CW    = pbtp_pkg::CFG_W;

    localparam logic [W-1:0]  ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0] ONE_S   = SW'(ONE);
    localparam logic [AW-1:0] IDX_MAX = AW'(MAX_PROBLEMS);
    localparam logic [CW:0]   NP_MAX  = (CW + 1)'(MAX_PROBLEMS);

    // Configuration registers.
    pbtp_pkg::t_cfg cfg;

    pbtp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer and datapath registers.
    pbtp_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [W-1:0]     r_hi, n_hi;
    logic [SW-1:0]    r_sum, n_sum;
    logic [W-1:0]     r_d0, n_d0;
    logic [W-1:0]     r_all, n_all;
    logic [W-1:0]     r_below, n_below;
    logic [DEPTH-1:0] r_vld, n_vld;
    logic [CW-1:0]    r_pidx, n_pidx;
    logic [W-1:0]     r_p, n_p;
    logic             r_last, n_last;
    logic             r_team_end, n_team_end;
    logic             r_out_valid, n_out_valid;
    logic [W-1:0]     r_out_data, n_out_data;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_zero;

    // Distribution store.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;

    pbtp_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_dist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared multiply-accumulate unit.
    logic signed [W:0] mac_a;
    logic [W-1:0]      mac_b;
    logic              mac_add_en;
    logic [W-1:0]      mac_res;

    pbtp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_a      (mac_a),
        .i_b      (mac_b),
        .i_add_en (mac_add_en),
        .i_hi     (r_hi),
        .o_res    (mac_res)
    );

    // An entry that has not been written since the last clear reads as its reset value:
    // 1.0 for entry zero, zero for every other entry.
    logic [W-1:0] rd_val;
    assign rd_val = r_rd_vld ? ram_rdata : (r_rd_zero ? ONE : '0);

    // Input conditioning and team-end detection, evaluated at acceptance, plus the sweep and answer helpers.
    logic [W-1:0]  prob_sat;
    logic [CW:0]   np;
    logic [CW-1:0] pidx_inc;
    logic          team_end;
    logic [W-1:0]  lo;
    logic          sum_incl;
    logic [W-1:0]  sum_sat;
    logic [W-1:0]  answer;

    always_comb begin
        prob_sat = (i_in.success_prob > ONE) ? ONE : i_in.success_prob;
        if (cfg.num_problems == '0) begin
            np = (CW + 1)'(1);
        end else if ({1'b0, cfg.num_problems} > NP_MAX) begin
            np = NP_MAX;
        end else begin
            np = {1'b0, cfg.num_problems};
        end
        pidx_inc = r_pidx + CW'(1);
        team_end = ({1'b0, pidx_inc} >= np);
        // Entry below entry zero is taken as zero.
        lo       = (r_idx == '0) ? '0 : rd_val;
        // Entries 1 .. min-1 go into the below-minimum sum.
        sum_incl = (r_idx != '0) && (32'(r_idx) < 32'(cfg.min_champion_solved));
        sum_sat  = (r_sum > ONE_S) ? ONE : r_sum[W-1:0];
        answer   = (r_all > r_below) ? (r_all - r_below) : '0;
    end

    assign i_in.ready        = (r_state == pbtp_pkg::ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.answer_prob = r_out_data;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_hi        = r_hi;
        n_sum       = r_sum;
        n_d0        = r_d0;
        n_all       = r_all;
        n_below     = r_below;
        n_vld       = r_vld;
        n_pidx      = r_pidx;
        n_p         = r_p;
        n_last      = r_last;
        n_team_end  = r_team_end;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        ram_raddr   = IDX_MAX;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = mac_res;
        mac_a       = $signed({1'b0, lo}) - $signed({1'b0, r_hi});
        mac_b       = r_p;
        mac_add_en  = 1'b0;

        case (r_state)
            pbtp_pkg::ST_IDLE: begin
                // The read of the top entry is already under way while idle.
                if (i_in.valid) begin
                    n_p        = prob_sat;
                    n_last     = i_in.last_team;
                    n_team_end = team_end;
                    n_pidx     = team_end ? '0 : pidx_inc;
                    n_state    = pbtp_pkg::ST_FILL;
                end
            end
            pbtp_pkg::ST_FILL: begin
                ram_raddr = IDX_MAX - AW'(1);
                n_hi      = rd_val;
                n_idx     = IDX_MAX;
                n_sum     = '0;
                n_state   = pbtp_pkg::ST_SWEEP;
            end
            pbtp_pkg::ST_SWEEP: begin
                ram_raddr    = r_idx - AW'(2);
                mac_add_en   = 1'b1;
                ram_we       = 1'b1;
                n_vld[r_idx] = 1'b1;
                n_hi         = lo;
                n_sum        = r_sum + (sum_incl ? SW'(mac_res) : '0);
                if (r_idx == '0) begin
                    n_d0    = mac_res;
                    n_state = r_team_end ? pbtp_pkg::ST_MUL_NZ : pbtp_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            pbtp_pkg::ST_MUL_NZ: begin
                mac_a   = $signed({1'b0, r_all});
                mac_b   = ONE - r_d0;
                n_all   = mac_res;
                n_state = pbtp_pkg::ST_MUL_BM;
            end
            pbtp_pkg::ST_MUL_BM: begin
                mac_a   = $signed({1'b0, r_below});
                mac_b   = sum_sat;
                n_below = mac_res;
                n_state = pbtp_pkg::ST_DONE;
            end
            pbtp_pkg::ST_DONE: begin
                // Back to the point mass at zero for the next team.
                n_vld = '0;
                if (!r_last) begin
                    n_state = pbtp_pkg::ST_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = answer;
                    n_all       = ONE;
                    n_below     = ONE;
                    n_state     = pbtp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbtp_pkg::ST_IDLE;
            end
        endcase
    end

    // Valid bit of the entry being read, captured alongside the registered RAM read.
    assign n_rd_vld = (ram_raddr <= IDX_MAX) ? r_vld[ram_raddr] : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbtp_pkg::ST_IDLE;
            r_vld       <= '0;
            r_pidx      <= '0;
            r_all       <= ONE;
            r_below     <= ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_pidx      <= n_pidx;
            r_all       <= n_all;
            r_below     <= n_below;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_hi       <= n_hi;
        r_sum      <= n_sum;
        r_d0       <= n_d0;
        r_p        <= n_p;
        r_last     <= n_last;
        r_team_end <= n_team_end;
        r_out_data <= n_out_data;
        r_rd_vld   <= n_rd_vld;
        r_rd_zero  <= (ram_raddr == '0);
    end

`ifndef SYNTHESIS
    // Once a probability is taken the core is busy with its sweep.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("core still ready in the cycle after accepting a transaction");

    // A case result only ever comes from the end of a team.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pbtp_pkg::ST_DONE))
        else $error("output became valid outside the team-end step");

    // A case probability never exceeds 1.0.
    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data <= ONE))
        else $error("case probability above 1.0");
`endif

endmodule

FILE: tb/tb_poisson_binomial_team_probability_core.sv
// Self-checking testbench for the Poisson-binomial team probability core.
`timescale 1ns / 1ps

module tb_poisson_binomial_team_probability_core;

    localparam int MAXP          = pbtp_pkg::MAX_PROBLEMS_DEF;
    localparam int FRAC          = pbtp_pkg::FRAC_BITS_DEF;
    localparam int ONE           = 1 << FRAC;
    localparam int PROB_MAX      = (1 << (FRAC + 1)) - 1;
    // Time allowed for a team-closing probability to finish, with ample margin.
    localparam int SETTLE_CYCLES = 2 * (MAXP + 6);
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int CYCLE_LIMIT   = 600000;

    // Predicts the case probabilities the core should produce, in the order it produces them,
    // and checks each answer transaction against the oldest prediction still waiting.
    class case_answer_board;
        bit [63:0]   pmf [0:MAXP];
        bit [63:0]   nz_prod;
        bit [63:0]   bm_prod;
        bit [5:0]    taken;
        bit [5:0]    cfg_problems;
        bit [5:0]    cfg_min;
        logic [16:0] expected_answers [$];
        int          errors;

        function new();
            cfg_problems = pbtp_pkg::NUM_PROBLEMS_RST;
            cfg_min      = pbtp_pkg::MIN_CHAMP_RST;
            nz_prod      = ONE;
            bm_prod      = ONE;
            taken        = 0;
            errors       = 0;
            restart_team();
        endfunction

        function bit [63:0] clip(bit [63:0] v);
            return (v > ONE) ? 64'(ONE) : v;
        endfunction

        function void restart_team();
            foreach (pmf[j]) begin
                pmf[j] = 0;
            end
            pmf[0] = ONE;
        endfunction

        function void set_register(pbtp_pkg::t_reg_idx which, bit [5:0] value);
            if (which == pbtp_pkg::REG_NUM_PROBLEMS) begin
                cfg_problems = value;
            end else begin
                cfg_min = value;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        // Folds one accepted probability into the solved-count distribution; closes teams.
        function void note_probability(logic [16:0] prob, logic last);
            bit [63:0] p;
            bit [63:0] q;
            bit [63:0] sum;
            bit [63:0] answer;
            int        team_len;
            int        top;
            int        j;
            p = clip(64'(prob));
            q = ONE - p;
            team_len = cfg_problems;
            if (team_len < 1) begin
                team_len = 1;
            end
            if (team_len > MAXP) begin
                team_len = MAXP;
            end
            for (j = MAXP; j >= 1; j--) begin
                pmf[j] = clip((pmf[j-1] * p + pmf[j] * q) >> FRAC);
            end
            pmf[0] = clip((pmf[0] * q) >> FRAC);
            taken = taken + 6'd1;
            if (int'(taken) < team_len) begin
                return;
            end
            top = cfg_min;
            if (top > MAXP + 1) begin
                top = MAXP + 1;
            end
            sum = 0;
            for (j = 1; j < top; j++) begin
                sum += pmf[j];
            end
            nz_prod = clip((clip(nz_prod) * clip(ONE - pmf[0])) >> FRAC);
            bm_prod = clip((clip(bm_prod) * clip(sum)) >> FRAC);
            restart_team();
            taken = 0;
            if (!last) begin
                return;
            end
            answer = (nz_prod > bm_prod) ? nz_prod - bm_prod : 64'd0;
            expected_answers.push_back(answer[16:0]);
            nz_prod = ONE;
            bm_prod = ONE;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_answer(logic [16:0] got);
            logic [16:0] want;
            if (expected_answers.size() == 0) begin
                report($sformatf("answer_prob %0d arrived with no case outstanding", got));
            end else begin
                want = expected_answers.pop_front();
                if (got !== want) begin
                    report($sformatf("answer_prob %0d, predicted %0d", got, want));
                end
            end
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pbtp_pkg::APB_AW-1:0]   paddr;
    logic [pbtp_pkg::APB_DW-1:0]   pwdata;
    logic [pbtp_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    pbtp_in_if  prob_if ();
    pbtp_out_if ans_if ();

    poisson_binomial_team_probability_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (prob_if),
        .o_out   (ans_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    case_answer_board board;

    int items_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stretch_left  = 0;
    int ready_mode    = 0;
    int cycle_count   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The run is bounded: a hang anywhere in the core ends it as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_poisson_binomial_team_probability_core NOT OK");
            $finish;
        end
    end

    // Answer receiver. It alternates between stretches that are always ready, stretches
    // that stall at random and stretches that stall most of the time. When the stimulus
    // asks for it, it holds ready low for a long count of cycles so that one answer sits
    // in the output register, the next case finishes behind it and the core must stop
    // taking probabilities.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ans_if.ready <= 1'b0;
        end else begin
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ans_if.ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(20, 300);
                    ready_mode   = $urandom_range(0, 2);
                end
                stretch_left--;
                case (ready_mode)
                    0: ans_if.ready <= 1'b1;
                    1: ans_if.ready <= ($urandom_range(0, 1) != 0);
                    default: ans_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Every answer transaction is checked as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && ans_if.valid && ans_if.ready) begin
            board.check_answer(ans_if.answer_prob);
        end
    end

    // Mostly ordinary probabilities, with plenty of the exact ends of the range, values
    // just under one (so the products stay away from zero over several teams) and values
    // above one that the core must saturate.
    function automatic logic [16:0] pick_probability();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return 17'd0;
        end
        if (roll < 20) begin
            return 17'(ONE);
        end
        if (roll < 25) begin
            return 17'($urandom_range(ONE + 1, PROB_MAX));
        end
        if (roll < 45) begin
            return 17'($urandom_range(ONE - 2048, ONE));
        end
        return 17'($urandom_range(0, ONE));
    endfunction

    // Offers one probability and returns in the time step of its acceptance, with valid
    // still high so that a following call can carry straight on. The sender works in
    // bursts; between bursts valid usually drops for a random gap.
    task automatic send_item(input logic [16:0] prob, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                prob_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        prob_if.valid        <= 1'b1;
        prob_if.success_prob <= prob;
        prob_if.last_team    <= last;
        do begin
            @(posedge i_clk);
        end while (!(prob_if.valid && prob_if.ready));
        board.note_probability(prob, last);
        items_sent++;
    endtask

    // Stops offering, waits for every predicted answer, then lets the core finish any
    // probability that produces no answer before anything else happens.
    task automatic settle();
        prob_if.valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase held until pready, then idle.
    task automatic write_reg(input pbtp_pkg::t_reg_idx which,
                             input logic [pbtp_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pbtp_pkg::APB_AW'({which, 2'b00});
        pwdata  <= pbtp_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(which, value);
        @(posedge i_clk);
    endtask

    task automatic set_config(input int problems, input int minimum);
        settle();
        write_reg(pbtp_pkg::REG_NUM_PROBLEMS, pbtp_pkg::CFG_W'(problems));
        write_reg(pbtp_pkg::REG_MIN_CHAMP, pbtp_pkg::CFG_W'(minimum));
    endtask

    initial begin : stimulus
        int roll;
        int problems;
        int minimum;
        int team_len;
        int cases;
        int teams;
        int random_start;
        logic flag;

        board = new();
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        prob_if.valid        <= 1'b0;
        prob_if.success_prob <= '0;
        prob_if.last_team    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Two problems per team: a last-team flag on the first probability
        // must be ignored, the team still ends on its second one, and a value above one
        // is treated as exactly one.
        set_config(2, 2);
        send_item(17'd0, 1'b1);
        send_item(17'(ONE), 1'b0);
        send_item(17'(PROB_MAX), 1'b0);
        send_item(17'(ONE - 1), 1'b1);
        send_item(17'd1, 1'b0);
        send_item(17'(ONE / 2), 1'b1);

        // A count of zero behaves as one; a minimum of zero leaves the below-minimum sum
        // empty. A certain failure gives a zero answer.
        set_config(0, 0);
        send_item(17'(ONE), 1'b1);
        send_item(17'd0, 1'b1);

        // A count above the maximum is clamped to it, then lowered part way through the
        // team: the next probability ends the team since the count is already reached.
        // The minimum lies beyond the count, so the sum covers every entry above zero.
        set_config(63, 63);
        send_item(17'd43690, 1'b1);
        send_item(17'd21845, 1'b0);
        send_item(17'h15555, 1'b1);
        set_config(3, 63);
        send_item(17'd50000, 1'b1);

        // Single-problem teams with a minimum of one and then of two.
        set_config(1, 1);
        send_item(17'(ONE), 1'b0);
        send_item(17'(ONE), 1'b1);
        set_config(1, 2);
        send_item(17'(ONE / 2), 1'b0);
        send_item(17'(ONE), 1'b1);

        // Back-pressure: every probability closes a case while the receiver holds off,
        // so answers pile up behind the output register and the input has to stall.
        set_config(1, 1);
        hold_requests++;
        repeat (24) send_item(pick_probability(), 1'b1);

        // Random part: whole cases of complete teams under a fresh setting each phase,
        // mostly with short teams so that answers come often. Flags on probabilities that
        // do not close a team are noise, an occasional team closes a case early, and now
        // and then a phase stops part way through a team so that the next setting
        // changes the count under it.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                problems = $urandom_range(1, 6);
            end else if (roll < 80) begin
                problems = $urandom_range(7, 20);
            end else if (roll < 88) begin
                problems = ($urandom_range(0, 1) != 0) ? MAXP : 30;
            end else if (roll < 94) begin
                problems = 0;
            end else begin
                problems = $urandom_range(MAXP + 1, 63);
            end
            team_len = (problems < 1) ? 1 : ((problems > MAXP) ? MAXP : problems);
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                minimum = $urandom_range(0, team_len + 1);
            end else if (roll < 80) begin
                minimum = $urandom_range(0, 1);
            end else begin
                minimum = $urandom_range(team_len, 63);
            end
            set_config(problems, minimum);

            cases = (team_len > 12) ? 1 : $urandom_range(1, 4);
            repeat (cases) begin
                teams = $urandom_range(1, (team_len > 12) ? 2 : 4);
                for (int t = 0; t < teams; t++) begin
                    for (int k = 0; k < team_len; k++) begin
                        if (k == team_len - 1) begin
                            flag = (t == teams - 1) ? ($urandom_range(0, 19) != 0)
                                                    : ($urandom_range(0, 9) == 0);
                        end else begin
                            flag = ($urandom_range(0, 3) == 0);
                        end
                        send_item(pick_probability(), flag);
                    end
                end
            end
            if (team_len > 1 && $urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, team_len - 1)) begin
                    send_item(pick_probability(), 1'($urandom_range(0, 1)));
                end
            end
        end

        // Drain: every predicted answer must arrive, and nothing may follow it.
        settle();
        if (board.pending() != 0) begin
            board.report($sformatf("%0d answers never arrived", board.pending()));
        end
        if (board.errors == 0) begin
            $display("tb_poisson_binomial_team_probability_core OK");
        end else begin
            $display("tb_poisson_binomial_team_probability_core NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/pbtp_pkg.sv
hdl/pbtp_in_if.sv
hdl/pbtp_out_if.sv
hdl/pbtp_ram.sv
hdl/pbtp_mac.sv
hdl/pbtp_cfg.sv
hdl/poisson_binomial_team_probability_core.sv
tb/tb_poisson_binomial_team_probability_core.sv
